@@ rtl/slcrc_pkg.sv @@
`default_nettype none

package slcrc_pkg;

  // Result item kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_CRC_ERR = 2'd2;
  localparam logic [1:0] KIND_LEN_ERR = 2'd3;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_ACK_COMMAND = 2'd2;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
  localparam logic [7:0] ACK_COMMAND_RST = 8'h31;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] MIN_LEN  = 8'd2;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] ack_command;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  command;
    logic [7:0]  pbyte;
    logic [7:0]  pindex;
    logic [31:0] good_count;
    logic [31:0] bad_count;
    logic        ack;
  } res_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/slcrc_parser.sv @@
`default_nettype none

module slcrc_parser #(
  parameter int COUNTER_BITS = 32
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                step,
  input  wire  [7:0]         rx_byte,
  input  slcrc_pkg::cfg_t    cfg,
  output slcrc_pkg::res_t    res
);
  import slcrc_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_LEN   = 3'd2,
    PH_CMD   = 3'd3,
    PH_PAY   = 3'd4,
    PH_CRC   = 3'd5
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [7:0]              crc_r, crc_nxt;
  logic [7:0]              rem_r, rem_nxt;
  logic [7:0]              cmd_r, cmd_nxt;
  logic [7:0]              pos_r, pos_nxt;
  logic [COUNTER_BITS-1:0] good_r, good_nxt;
  logic [COUNTER_BITS-1:0] bad_r, bad_nxt;
  logic                    ack_r, ack_nxt;

  always_comb begin
    phase_nxt  = phase_r;
    crc_nxt    = crc_r;
    rem_nxt    = rem_r;
    cmd_nxt    = cmd_r;
    pos_nxt    = pos_r;
    good_nxt   = good_r;
    bad_nxt    = bad_r;
    ack_nxt    = ack_r;
    res.valid   = 1'b0;
    res.kind    = KIND_PAYLOAD;
    res.command = 8'd0;
    res.pbyte   = 8'd0;
    res.pindex  = 8'd0;
    case (phase_r)
      PH_HUNT2: begin
        if (rx_byte == cfg.sync_second) begin
          crc_nxt   = crc8_update(crc_r, rx_byte);
          phase_nxt = PH_LEN;
        end else if (rx_byte == cfg.sync_first) begin
          // repeated first sync byte: restart the pattern
          crc_nxt = crc8_update(8'd0, rx_byte);
        end else begin
          phase_nxt = PH_HUNT1;
        end
      end
      PH_LEN: begin
        if (rx_byte < MIN_LEN) begin
          phase_nxt = PH_HUNT1;
          res.valid = 1'b1;
          res.kind  = KIND_LEN_ERR;
        end else begin
          crc_nxt   = crc8_update(crc_r, rx_byte);
          rem_nxt   = rx_byte - MIN_LEN;
          phase_nxt = PH_CMD;
        end
      end
      PH_CMD: begin
        crc_nxt   = crc8_update(crc_r, rx_byte);
        cmd_nxt   = rx_byte;
        pos_nxt   = 8'd0;
        phase_nxt = (rem_r == 8'd0) ? PH_CRC : PH_PAY;
      end
      PH_PAY: begin
        crc_nxt     = crc8_update(crc_r, rx_byte);
        pos_nxt     = pos_r + 8'd1;
        rem_nxt     = rem_r - 8'd1;
        if (rem_r == 8'd1) begin
          phase_nxt = PH_CRC;
        end
        res.valid   = 1'b1;
        res.kind    = KIND_PAYLOAD;
        res.command = cmd_r;
        res.pbyte   = rx_byte;
        res.pindex  = pos_r;
      end
      PH_CRC: begin
        phase_nxt   = PH_HUNT1;
        res.valid   = 1'b1;
        res.command = cmd_r;
        if (rx_byte == crc_r) begin
          good_nxt = good_r + 1'b1;
          if (cmd_r == cfg.ack_command) begin
            ack_nxt = 1'b1;
          end
          res.kind = KIND_GOOD;
        end else begin
          bad_nxt  = bad_r + 1'b1;
          res.kind = KIND_CRC_ERR;
        end
      end
      default: begin
        if (rx_byte == cfg.sync_first) begin
          crc_nxt   = crc8_update(8'd0, rx_byte);
          phase_nxt = PH_HUNT2;
        end else begin
          phase_nxt = PH_HUNT1;
        end
      end
    endcase
    // report the low 32 bits of the counters, zero-extended when narrower
    res.good_count = 32'(good_nxt);
    res.bad_count  = 32'(bad_nxt);
    res.ack        = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      crc_r   <= 8'd0;
      rem_r   <= 8'd0;
      cmd_r   <= 8'd0;
      pos_r   <= 8'd0;
      good_r  <= '0;
      bad_r   <= '0;
      ack_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      rem_r   <= rem_nxt;
      cmd_r   <= cmd_nxt;
      pos_r   <= pos_nxt;
      good_r  <= good_nxt;
      bad_r   <= bad_nxt;
      ack_r   <= ack_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sync_length_crc8_frame_receiver.sv @@
// Datapath: an accepted item goes to the input register, then through the parse and CRC logic
// into the result register; the byte-wide CRC update and frame parser are combinational.
// Throughput: one item per cycle unless the result side stalls.
// Stalls on the result side back up through the input register only when both stages are full.
// Reset (rst_n low at a rising edge, synchronous) empties both stages, returns the parser to the
// sync hunt, clears CRC, counters and acknowledge flag and loads the register reset values.
`default_nettype none

module sync_length_crc8_frame_receiver #(
  parameter int COUNTER_BITS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_item_kind,
  output logic [7:0]  out_frame_command,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_payload_index,
  output logic [31:0] out_good_frame_count,
  output logic [31:0] out_bad_frame_count,
  output logic        out_ack_seen,
  // configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import slcrc_pkg::*;

  // Configuration registers
  logic [7:0] sync_first_r;
  logic [7:0] sync_second_r;
  logic [7:0] ack_command_r;
  cfg_t       cfg;

  // Input stage
  logic       in_valid_r;
  logic [7:0] rx_byte_r;

  // Result stage
  logic       out_valid_r;
  res_t       res;
  res_t       res_r;

  logic       advance;
  logic       step;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
      ack_command_r <= ACK_COMMAND_RST;
    end else if (cfg_wr) begin
      // decode on the word index; writes past the last register are dropped
      case (paddr[3:2])
        REG_SYNC_FIRST:  sync_first_r  <= pwdata[7:0];
        REG_SYNC_SECOND: sync_second_r <= pwdata[7:0];
        REG_ACK_COMMAND: ack_command_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SYNC_FIRST:  prdata = {24'd0, sync_first_r};
      REG_SYNC_SECOND: prdata = {24'd0, sync_second_r};
      REG_ACK_COMMAND: prdata = {24'd0, ack_command_r};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg.sync_first  = sync_first_r;
  assign cfg.sync_second = sync_second_r;
  assign cfg.ack_command = ack_command_r;

  // Advance the result register when it is empty or being drained
  assign advance  = !out_valid_r || out_ready;
  // Take a new item whenever the input register is empty or moves on
  assign in_ready = !in_valid_r || advance;
  // The buffered item is consumed by the parser in this cycle
  assign step     = in_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  // Hold the byte payload; no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rx_byte_r <= in_rx_byte;
    end
  end

  slcrc_parser #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (rx_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register: a byte that yields no result just drops out here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step && res.valid) begin
      res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_item_kind        = res_r.kind;
  assign out_frame_command    = res_r.command;
  assign out_payload_byte     = res_r.pbyte;
  assign out_payload_index    = res_r.pindex;
  assign out_good_frame_count = res_r.good_count;
  assign out_bad_frame_count  = res_r.bad_count;
  assign out_ack_seen         = res_r.ack;

endmodule

`default_nettype wire

@@ rtl/slcrc_checker.sv @@
`default_nettype none

module slcrc_checker #(
  parameter int COUNTER_BITS = 32
) (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  out_item_kind,
  input wire [7:0]  out_payload_byte,
  input wire [7:0]  out_payload_index,
  input wire [31:0] out_good_frame_count,
  input wire [31:0] out_bad_frame_count,
  input wire        out_ack_seen
);
  import slcrc_pkg::*;

  localparam logic [31:0] CNT_MASK =
    (COUNTER_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << COUNTER_BITS) - 64'd1);

  logic [31:0] last_good_r;
  logic [31:0] last_bad_r;
  logic        ack_seen_r;
  logic [31:0] good_inc;
  logic [31:0] bad_inc;

  assign good_inc = (last_good_r + 32'd1) & CNT_MASK;
  assign bad_inc  = (last_bad_r + 32'd1) & CNT_MASK;

  // Track the counts and flag last delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_good_r <= 32'd0;
      last_bad_r  <= 32'd0;
      ack_seen_r  <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_good_r <= out_good_frame_count;
      last_bad_r  <= out_bad_frame_count;
      ack_seen_r  <= out_ack_seen;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_good_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item_kind == KIND_GOOD) ? (out_good_frame_count == good_inc)
                                               : (out_good_frame_count == last_good_r))
    else $error("good frame count out of step with good frame items");

  a_bad_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item_kind == KIND_CRC_ERR) ? (out_bad_frame_count == bad_inc)
                                                  : (out_bad_frame_count == last_bad_r))
    else $error("bad frame count out of step with CRC error items");

  a_ack_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ack_seen_r |-> out_ack_seen)
    else $error("acknowledge flag cleared");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item_kind != KIND_PAYLOAD) |->
      (out_payload_byte == 8'd0) && (out_payload_index == 8'd0))
    else $error("status item carries payload fields");

endmodule

bind sync_length_crc8_frame_receiver slcrc_checker #(
  .COUNTER_BITS(COUNTER_BITS)
) u_slcrc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_item_kind        (out_item_kind),
  .out_payload_byte     (out_payload_byte),
  .out_payload_index    (out_payload_index),
  .out_good_frame_count (out_good_frame_count),
  .out_bad_frame_count  (out_bad_frame_count),
  .out_ack_seen         (out_ack_seen)
);

`default_nettype wire
